/* hw/rtl/assert_macros.svh */
// Assertion macros for the glyph cache RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GCA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define GCA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define GCA_ASSERT(label, clk, rst_n, prop)
`define GCA_ASSERT_NR(label, clk, prop)
`endif
`endif

/* hw/rtl/gca_pkg.sv */
// Shared types and constants for the glyph cache atlas packer.
// No dependencies.
`default_nettype none
package gca_pkg;
  localparam int KEY_W = 18;
  localparam int PLACE_W = 26;
  localparam int MET_W = 45;
  localparam int ENTRY_W = KEY_W + PLACE_W + MET_W;

  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_RETRY = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  localparam logic [1:0] CFG_ATLAS_WIDTH = 2'd0;
  localparam logic [1:0] CFG_CELL_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CELL_BASELINE = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [12:0] left;
    logic [12:0] top;
    logic [7:0] off_x;
    logic [11:0] off_y;
    logic [8:0] adv;
    logic [7:0] bw;
    logic [7:0] rows;
  } entry_t;
endpackage
`default_nettype wire

/* hw/rtl/glyph_cache_atlas_packer_core.sv */
// Top level of the glyph cache atlas packer: sequencer, search, placement.
// Depends on gca_pkg, gca_table and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// A request is taken when start is high and busy is low; busy then stays high
// until the single result is shown for one cycle with out_valid. The receiver
// cannot stall. A hit needs at most log2(TABLE_DEPTH)+1 binary-search probes, each a
// table read followed by a compare; a miss then shifts each entry above the insert
// point up by one, with a read and a write per entry through the table's read and
// write ports. Config writes are accepted only while idle.
module glyph_cache_atlas_packer_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_ATLAS_HEIGHT = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [15:0]       in_letter,
  input  wire logic [1:0]        in_style,
  input  wire logic signed [7:0] in_bearing_left,
  input  wire logic signed [10:0] in_bearing_top,
  input  wire logic [7:0]        in_bitmap_width,
  input  wire logic [7:0]        in_bitmap_rows,
  input  wire logic [13:0]       in_advance_raw,
  input  wire logic              in_render_ok,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [12:0]       cfg_data,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [12:0]            out_tex_left,
  output logic [12:0]            out_tex_top,
  output logic [12:0]            out_tex_right,
  output logic [12:0]            out_tex_bottom,
  output logic signed [7:0]      out_offset_x,
  output logic [11:0]            out_offset_y,
  output logic [8:0]             out_advance,
  output logic [8:0]             out_entry_count
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_CMP, S_PLACE, S_SHRD, S_SHWR, S_INS, S_EMITRD, S_EMIT
  } state_t;

  state_t state_r;
  logic [12:0] atlas_width_r, cell_height_r;
  logic [11:0] cell_baseline_r;
  logic [CW-1:0] count_r, lo_r, hi_r, mid_r, shift_r, pos_r;
  logic [12:0] pen_x_r;
  logic signed [14:0] pen_y_r;
  logic [13:0] atlas_h_r;
  logic retry_r;
  logic [1:0] status_r;
  gca_pkg::entry_t new_r;

  // captured request
  logic [15:0] letter_r;
  logic [1:0] style_r;
  logic signed [7:0] bl_r;
  logic signed [10:0] bt_r;
  logic [7:0] bw_r, rows_r;
  logic [13:0] raw_r;
  logic ok_r;

  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  gca_pkg::entry_t wr_data, rd_data;

  gca_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  logic [gca_pkg::KEY_W-1:0] key;
  assign key = {style_r, letter_r};

  // table port selection
  always_comb begin
    wr_en = 1'b0;
    wr_addr = shift_r[AW-1:0];
    wr_data = rd_data;
    rd_addr = mid_r[AW-1:0];
    case (state_r)
      S_PROBE:  rd_addr = mid_r[AW-1:0];
      S_SHRD:   rd_addr = AW'(shift_r - CW'(1));
      S_SHWR: begin
        wr_en = 1'b1;
        wr_addr = shift_r[AW-1:0];
      end
      S_INS: begin
        wr_en = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_data = new_r;
      end
      S_EMITRD: rd_addr = pos_r[AW-1:0];
      default: ;
    endcase
  end

  // placement arithmetic (one attempt, from current pen)
  logic signed [15:0] px0, px1, ch_s, py1, bl_s, need, ah1, oy_w, left_w, top_w, step_w;
  logic signed [15:0] npx_w;
  logic wrap, grow, fail_h, fail;
  logic [11:0] oy;
  logic [8:0] adv;
  logic [5:0] frac;
  always_comb begin
    bl_s = 16'(bl_r);
    ch_s = 16'($signed({1'b0, cell_height_r}));
    px0 = 16'($signed({1'b0, pen_x_r}));
    if (bl_r < 0) px0 = px0 - bl_s;
    wrap = (px0 + bl_s + 16'(bw_r)) > 16'($signed({1'b0, atlas_width_r}));
    px1 = px0;
    py1 = 16'(pen_y_r);
    ah1 = 16'($signed({1'b0, atlas_h_r}));
    fail_h = 1'b0;
    if (wrap) begin
      px1 = (bl_r < 0) ? -bl_s : 16'sd0;
      py1 = 16'(pen_y_r) + ch_s;
      need = py1 + ch_s;
      grow = need >= ah1;
      if (grow) begin
        if (need > 16'(MAX_ATLAS_HEIGHT)) fail_h = 1'b1;
        ah1 = need;
      end
    end else begin
      need = 16'sd0;
      grow = 1'b0;
    end
    oy_w = 16'($signed({1'b0, cell_baseline_r})) - 16'(bt_r);
    if (oy_w < 0) oy_w = 16'sd0;
    if (oy_w > 16'sd4095) oy_w = 16'sd4095;
    oy = oy_w[11:0];
    left_w = px1 + bl_s;
    if (left_w < 0) left_w = 16'sd0;
    if (left_w > 16'sd8191) left_w = 16'sd8191;
    top_w = py1 + oy_w;
    if (top_w < 0) top_w = 16'sd0;
    if (top_w > 16'sd8191) top_w = 16'sd8191;
    frac = raw_r[5:0];
    adv = {1'b0, raw_r[13:6]};
    if (frac > 6'd32 || (frac == 6'd32 && raw_r[6])) adv = adv + 9'd1;
    step_w = 16'(bw_r) + bl_s;
    if (16'($signed({1'b0, adv})) + 16'sd1 > step_w) step_w = 16'($signed({1'b0, adv})) + 16'sd1;
    npx_w = px1 + step_w;
    if (npx_w > 16'sd8191) npx_w = 16'sd8191;
    fail = !ok_r || (count_r >= CW'(TABLE_DEPTH)) || fail_h;
  end

  logic [13:0] bottom_w;
  assign bottom_w = {1'b0, rd_data.top} + 14'(rd_data.rows);

  assign busy = !rst_n || (state_r != S_IDLE);
  assign cfg_ready = rst_n && (state_r == S_IDLE) && !start;

  // sequencer and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      atlas_width_r <= 13'd512;
      cell_height_r <= 13'd24;
      cell_baseline_r <= 12'd19;
      count_r <= '0;
      pen_x_r <= 13'd512;
      pen_y_r <= -15'sd24;
      atlas_h_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            case (cfg_index)
              gca_pkg::CFG_ATLAS_WIDTH:   atlas_width_r <= cfg_data;
              gca_pkg::CFG_CELL_HEIGHT:   cell_height_r <= cfg_data;
              gca_pkg::CFG_CELL_BASELINE: cell_baseline_r <= cfg_data[11:0];
              default: ;
            endcase
          end
          if (start) begin
            letter_r <= in_letter; style_r <= in_style;
            bl_r <= in_bearing_left; bt_r <= in_bearing_top;
            bw_r <= in_bitmap_width; rows_r <= in_bitmap_rows;
            raw_r <= in_advance_raw; ok_r <= in_render_ok;
            lo_r <= '0; hi_r <= count_r;
            mid_r <= CW'({1'b0, count_r} >> 1);
            retry_r <= 1'b0;
            state_r <= (count_r == '0) ? S_PLACE : S_PROBE;
          end
        end
        // wait for registered read
        S_PROBE: state_r <= S_CMP;
        S_CMP: begin
          if (key == rd_data.key) begin
            status_r <= gca_pkg::ST_HIT;
            state_r <= S_EMIT;
          end else begin
            logic [CW-1:0] nlo, nhi;
            nlo = lo_r; nhi = hi_r;
            if (key > rd_data.key) nlo = mid_r + CW'(1);
            else nhi = mid_r;
            lo_r <= nlo; hi_r <= nhi;
            mid_r <= CW'(({1'b0, nlo} + {1'b0, nhi}) >> 1);
            state_r <= (nlo < nhi) ? S_PROBE : S_PLACE;
          end
        end
        S_PLACE: begin
          if (fail) begin
            if (retry_r) begin
              status_r <= gca_pkg::ST_FAIL;
              count_r <= '0;
              out_valid <= 1'b1;
              out_status <= gca_pkg::ST_FAIL;
              out_tex_left <= '0; out_tex_top <= '0; out_tex_right <= '0;
              out_tex_bottom <= '0; out_offset_x <= '0; out_offset_y <= '0;
              out_advance <= '0; out_entry_count <= '0;
              state_r <= S_IDLE;
            end else begin
              retry_r <= 1'b1;
              count_r <= '0;
              pen_x_r <= atlas_width_r;
              pen_y_r <= -15'($signed({2'b0, cell_height_r}));
              atlas_h_r <= '0;
              lo_r <= '0;
            end
          end else begin
            new_r <= '{key: key, left: left_w[12:0], top: top_w[12:0], off_x: bl_r,
                       off_y: oy, adv: adv, bw: bw_r, rows: rows_r};
            pen_x_r <= npx_w[12:0];
            pen_y_r <= py1[14:0];
            atlas_h_r <= ah1[13:0];
            pos_r <= lo_r;
            shift_r <= count_r;
            status_r <= retry_r ? gca_pkg::ST_RETRY : gca_pkg::ST_INSERT;
            state_r <= (count_r > lo_r) ? S_SHRD : S_INS;
          end
        end
        S_SHRD: state_r <= S_SHWR;
        S_SHWR: begin
          shift_r <= shift_r - CW'(1);
          state_r <= (shift_r - CW'(1) > pos_r) ? S_SHRD : S_INS;
        end
        S_INS: begin
          count_r <= count_r + CW'(1);
          mid_r <= pos_r;
          state_r <= S_EMITRD;
        end
        S_EMITRD: state_r <= S_EMIT;
        S_EMIT: begin
          out_valid <= 1'b1;
          out_status <= status_r;
          out_tex_left <= rd_data.left;
          out_tex_top <= rd_data.top;
          out_tex_right <= rd_data.left + 13'(rd_data.bw);
          out_tex_bottom <= (bottom_w > 14'd8191) ? 13'd8191 : bottom_w[12:0];
          out_offset_x <= rd_data.off_x;
          out_offset_y <= rd_data.off_y;
          out_advance <= rd_data.adv;
          out_entry_count <= 9'(count_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  `GCA_ASSERT(a_cnt_bound, clk, rst_n, count_r <= CW'(TABLE_DEPTH))
  `GCA_ASSERT(a_out_ends, clk, rst_n, out_valid |-> state_r == S_IDLE)
  `GCA_ASSERT(a_hit_no_grow, clk, rst_n, (out_valid && out_status == gca_pkg::ST_HIT) |-> $stable(count_r))
  `GCA_ASSERT_NR(a_no_cfg_busy, clk, (busy |-> !cfg_ready))
endmodule
`default_nettype wire

/* hw/rtl/gca_table.sv */
// Glyph table memory: one write port, one registered read port.
// Depends on gca_pkg for the entry type.
`default_nettype none
module gca_table #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire gca_pkg::entry_t   wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output gca_pkg::entry_t        rd_data
);
  gca_pkg::entry_t mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

/* test/tb_glyph_cache_atlas_packer_core.sv */
// Self-checking testbench for glyph_cache_atlas_packer_core: directed and random requests
// against an in-bench predictor of the sorted glyph table and shelf packer.
// Depends on gca_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_glyph_cache_atlas_packer_core;

  localparam int TABLE_N = 256;
  localparam int MAX_H = 4096;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [15:0] letter;
    logic [1:0] style;
    logic signed [7:0] bl;
    logic signed [10:0] bt;
    logic [7:0] bw;
    logic [7:0] rows;
    logic [13:0] raw;
    logic ok;
  } glyph_req_t;

  typedef struct {
    logic [1:0] status;
    logic [12:0] left;
    logic [12:0] top;
    logic [12:0] right;
    logic [12:0] bottom;
    logic [7:0] off_x;
    logic [11:0] off_y;
    logic [8:0] adv;
    logic [8:0] count;
  } glyph_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_letter = '0;
  logic [1:0] in_style = '0;
  logic signed [7:0] in_bearing_left = '0;
  logic signed [10:0] in_bearing_top = '0;
  logic [7:0] in_bitmap_width = '0;
  logic [7:0] in_bitmap_rows = '0;
  logic [13:0] in_advance_raw = '0;
  logic in_render_ok = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [12:0] out_tex_left, out_tex_top, out_tex_right, out_tex_bottom;
  logic signed [7:0] out_offset_x;
  logic [11:0] out_offset_y;
  logic [8:0] out_advance, out_entry_count;

  glyph_cache_atlas_packer_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_letter(in_letter), .in_style(in_style), .in_bearing_left(in_bearing_left),
    .in_bearing_top(in_bearing_top), .in_bitmap_width(in_bitmap_width),
    .in_bitmap_rows(in_bitmap_rows), .in_advance_raw(in_advance_raw),
    .in_render_ok(in_render_ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_status(out_status), .out_tex_left(out_tex_left),
    .out_tex_top(out_tex_top), .out_tex_right(out_tex_right), .out_tex_bottom(out_tex_bottom),
    .out_offset_x(out_offset_x), .out_offset_y(out_offset_y), .out_advance(out_advance),
    .out_entry_count(out_entry_count)
  );

  // Predictor state: cached glyph table, shelf pen and registers
  logic [17:0] tab_key [TABLE_N];
  int tab_left [TABLE_N];
  int tab_top [TABLE_N];
  int tab_offx [TABLE_N];
  int tab_offy [TABLE_N];
  int tab_adv [TABLE_N];
  int tab_bw [TABLE_N];
  int tab_rows [TABLE_N];
  int cached_n = 0;
  int atlas_w = 512;
  int cell_h = 24;
  int cell_base = 19;
  int pen_x = 512;
  int pen_y = -24;
  int atlas_h = 0;

  glyph_res_t expected_glyphs [$];
  int errors = 0;
  int n_sent = 0;
  int n_status [4] = '{0, 0, 0, 0};
  int send_idle_pct = 0;
  int stall_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_cache_model();
    cached_n = 0;
    pen_x = atlas_w;
    pen_y = -cell_h;
    atlas_h = 0;
  endfunction

  function automatic glyph_res_t read_entry(int idx, logic [1:0] st);
    glyph_res_t r;
    int bottom;
    bottom = tab_top[idx] + tab_rows[idx];
    if (bottom > 8191) bottom = 8191;
    r.status = st;
    r.left = tab_left[idx];
    r.top = tab_top[idx];
    r.right = (tab_left[idx] + tab_bw[idx]) & 13'h1fff;
    r.bottom = bottom;
    r.off_x = tab_offx[idx];
    r.off_y = tab_offy[idx];
    r.adv = tab_adv[idx];
    r.count = cached_n & 9'h1ff;
    return r;
  endfunction

  // Place a missed glyph on the current shelf; leave state untouched on failure
  function automatic bit place_glyph(glyph_req_t q, int pos, logic [1:0] st,
                                     output glyph_res_t r);
    int bl, bt, bw, rows, px, py, ah, oy, left, top, step, npx, adv, frac;
    bl = q.bl;
    bt = q.bt;
    bw = q.bw;
    rows = q.rows;
    px = pen_x;
    py = pen_y;
    ah = atlas_h;
    r = '{default: '0};
    if (!q.ok || cached_n >= TABLE_N || pos > cached_n) return 1'b0;
    if (bl < 0) px -= bl;
    // wrap to a new shelf and grow the atlas when needed
    if (px + bl + bw > atlas_w) begin
      px = (bl < 0) ? -bl : 0;
      py += cell_h;
      if (py + cell_h >= ah) begin
        if (py + cell_h > MAX_H) return 1'b0;
        ah = py + cell_h;
      end
    end
    oy = cell_base - bt;
    if (oy < 0) oy = 0;
    if (oy > 4095) oy = 4095;
    left = px + bl;
    if (left < 0) left = 0;
    if (left > 8191) left = 8191;
    top = py + oy;
    if (top < 0) top = 0;
    if (top > 8191) top = 8191;
    // round 8.6 to nearest, ties to even
    adv = q.raw >> 6;
    frac = q.raw & 63;
    if (frac > 32 || (frac == 32 && adv[0])) adv++;
    step = bw + bl;
    if (adv + 1 > step) step = adv + 1;
    npx = px + step;
    if (npx > 8191) npx = 8191;
    for (int i = cached_n; i > pos; i--) begin
      tab_key[i] = tab_key[i-1];
      tab_left[i] = tab_left[i-1];
      tab_top[i] = tab_top[i-1];
      tab_offx[i] = tab_offx[i-1];
      tab_offy[i] = tab_offy[i-1];
      tab_adv[i] = tab_adv[i-1];
      tab_bw[i] = tab_bw[i-1];
      tab_rows[i] = tab_rows[i-1];
    end
    tab_key[pos] = {q.style, q.letter};
    tab_left[pos] = left;
    tab_top[pos] = top;
    tab_offx[pos] = bl & 8'hff;
    tab_offy[pos] = oy;
    tab_adv[pos] = adv;
    tab_bw[pos] = bw;
    tab_rows[pos] = rows;
    cached_n++;
    pen_x = npx;
    pen_y = py;
    atlas_h = ah;
    r = read_entry(pos, st);
    return 1'b1;
  endfunction

  function automatic glyph_res_t predict_glyph(glyph_req_t q);
    glyph_res_t r;
    logic [17:0] key;
    int lo, hi, mid;
    key = {q.style, q.letter};
    lo = 0;
    hi = cached_n;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (key > tab_key[mid]) lo = mid + 1;
      else if (key < tab_key[mid]) hi = mid;
      else return read_entry(mid, gca_pkg::ST_HIT);
    end
    if (place_glyph(q, lo, gca_pkg::ST_INSERT, r)) return r;
    clear_cache_model();
    if (place_glyph(q, 0, gca_pkg::ST_RETRY, r)) return r;
    r = '{default: '0};
    r.status = gca_pkg::ST_FAIL;
    return r;
  endfunction

  // Drive one request and hold it until the transfer; optionally idle afterwards
  task automatic send_glyph(glyph_req_t q);
    in_letter <= q.letter;
    in_style <= q.style;
    in_bearing_left <= q.bl;
    in_bearing_top <= q.bt;
    in_bitmap_width <= q.bw;
    in_bitmap_rows <= q.rows;
    in_advance_raw <= q.raw;
    in_render_ok <= q.ok;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_glyphs.push_back(predict_glyph(q));
    n_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_fields(int letter, int style, int bl, int bt, int bw, int rows,
                             int raw, bit ok);
    glyph_req_t q;
    q = '{letter, style, bl, bt, bw, rows, raw, ok};
    send_glyph(q);
  endtask

  // Drain, let the core settle, then write one register
  task automatic write_reg(logic [1:0] idx, int value);
    start <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      gca_pkg::CFG_ATLAS_WIDTH: atlas_w = value & 13'h1fff;
      gca_pkg::CFG_CELL_HEIGHT: cell_h = value & 13'h1fff;
      gca_pkg::CFG_CELL_BASELINE: cell_base = value & 12'hfff;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int w, int ch, int base);
    write_reg(gca_pkg::CFG_ATLAS_WIDTH, w);
    write_reg(gca_pkg::CFG_CELL_HEIGHT, ch);
    write_reg(gca_pkg::CFG_CELL_BASELINE, base);
  endtask

  function automatic glyph_req_t random_glyph();
    glyph_req_t q;
    q.letter = ($urandom_range(9) == 0) ? $urandom : $urandom_range(47);
    q.style = $urandom;
    q.bl = ($urandom_range(3) == 0) ? $urandom : $urandom_range(8) - 4;
    q.bt = ($urandom_range(3) == 0) ? $urandom : $urandom_range(30);
    q.bw = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4, 24);
    q.rows = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4, 24);
    q.raw = ($urandom_range(3) == 0) ? $urandom : $urandom_range(256, 1600);
    q.ok = ($urandom_range(19) != 0);
    return q;
  endfunction

  // Extremes of every field, rounding ties, hits and render errors
  task automatic test_field_extremes();
    send_fields(0, 0, 0, 0, 0, 0, 0, 1);
    send_fields(16'hffff, 3, -128, -1024, 255, 255, 16383, 1);
    send_fields(16'h8000, 1, 127, 1023, 255, 255, 32, 1);
    send_fields(16'h0100, 2, 0, 5, 10, 10, 96, 1);
    send_fields(16'h0101, 2, -5, 19, 10, 10, 64 + 33, 1);
    send_fields(16'h0102, 1, 3, -20, 200, 1, 31, 1);
    send_fields(16'hffff, 3, 0, 0, 0, 0, 0, 0);
    send_fields(0, 0, 1, 1, 1, 1, 1, 1);
    send_fields(16'h7fff, 0, 0, 0, 1, 1, 0, 0);
    send_fields(16'h5555, 1, 0, 0, 1, 1, 0, 1);
    send_fields(16'h5555, 1, 0, 0, 1, 1, 0, 1);
  endtask

  // Shelf past the height limit: clear and retry, glyph above the first shelf
  task automatic test_height_overflow();
    set_geometry(64, 4096, 4095);
    send_fields(1, 0, 0, 0, 60, 8, 64, 1);
    send_fields(2, 0, 0, 0, 60, 8, 64, 1);
    send_fields(3, 0, 0, 0, 60, 8, 64, 0);
    send_fields(4, 0, 0, 0, 0, 8, 64, 1);
    send_fields(5, 0, 0, -1024, 0, 255, 64, 1);
  endtask

  // Widest atlas: pen and left edge saturate
  task automatic test_pen_saturation();
    set_geometry(8191, 1, 0);
    write_reg(2'd3, 13'h1abc);
    send_fields(9, 0, 0, 0, 1, 1, 0, 0);
    send_fields(10, 0, 127, 0, 255, 255, 16383, 1);
    send_fields(11, 0, 127, 0, 255, 255, 16383, 1);
  endtask

  // Fill the table, then miss once more
  task automatic test_table_full();
    set_geometry(4096, 1, 0);
    for (int i = 0; i < TABLE_N; i++) send_fields(TABLE_N - 1 - i, 2, 0, 0, 1, 1, 0, 1);
    send_fields(77, 2, 0, 0, 1, 1, 0, 0);
    send_fields(1000, 2, 0, 0, 1, 1, 0, 1);
  endtask

  task automatic test_random_phase(int idle_pct, int w, int ch, int base, int count);
    send_idle_pct = idle_pct;
    set_geometry(w, ch, base);
    for (int i = 0; i < count; i++) begin
      // stretches without idling inside each phase
      if (idle_pct != 0) send_idle_pct = ((i / 40) % 3 == 2) ? 0 : idle_pct;
      send_glyph(random_glyph());
    end
  endtask

  // Compare each result with the oldest prediction
  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    glyph_res_t e;
    if (rst_n && out_valid) begin
      n_status[out_status]++;
      if (expected_glyphs.size() == 0) begin
        $display("%0t unexpected result status %0d", $time, out_status);
        errors++;
      end else begin
        e = expected_glyphs.pop_front();
        check_field("status", e.status, out_status);
        check_field("tex_left", e.left, out_tex_left);
        check_field("tex_top", e.top, out_tex_top);
        check_field("tex_right", e.right, out_tex_right);
        check_field("tex_bottom", e.bottom, out_tex_bottom);
        check_field("offset_x", e.off_x, out_offset_x[7:0]);
        check_field("offset_y", e.off_y, out_offset_y);
        check_field("advance", e.adv, out_advance);
        check_field("entry_count", e.count, out_entry_count);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", stall_cycles);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clear_cache_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_height_overflow();
    test_pen_saturation();
    test_table_full();
    test_random_phase(21, 512, 24, 19, 150);
    test_random_phase(48, 64, 1, 0, 150);
    test_random_phase(0, 4096, 4096, 4095, 40);
    test_random_phase(0, $urandom_range(64, 1024), $urandom_range(8, 64),
                      $urandom_range(0, 40), 130);
    start <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d requests over eight atlas geometries: %0d hits, %0d inserts,",
             n_sent, n_status[gca_pkg::ST_HIT], n_status[gca_pkg::ST_INSERT]);
    $display("%0d inserts after clear, %0d failures; %0d mismatches",
             n_status[gca_pkg::ST_RETRY], n_status[gca_pkg::ST_FAIL], errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/gca_pkg.sv
hw/rtl/gca_table.sv
hw/rtl/glyph_cache_atlas_packer_core.sv
test/tb_glyph_cache_atlas_packer_core.sv
